/* hdl/mtwd_pkg.sv */
// Shared types, constants and operation codes for the task watchdog table.
package mtwd_pkg;

   localparam int NUM_SLOTS_DEF = 8;
   localparam int KIND_W        = 3;
   localparam int SLOT_W        = 3;
   localparam int TIME_W        = 16;

   localparam logic [TIME_W-1:0] TICK_INC_RESET = TIME_W'(1);

   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   // write/read strobes and write data toward the slot store
   typedef struct packed {
      logic              rd_en;
      logic              wr_dl_en;
      logic              wr_el_en;
      logic [TIME_W-1:0] wr_dl;
      logic [TIME_W-1:0] wr_el;
   } mem_cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] elapsed;
   } mem_rd_type;

endpackage

/* hdl/mtwd_if.sv */
// Request and response channel interfaces of the task watchdog table.
interface mtwd_req_if;
   import mtwd_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SLOT_W-1:0] slot;
   logic [TIME_W-1:0] timeout_value;

   modport source (output valid, output kind, output slot, output timeout_value,
                   input ready);
   modport sink   (input valid, input kind, input slot, input timeout_value,
                   output ready);
endinterface

interface mtwd_rsp_if;
   import mtwd_pkg::*;

   logic              valid;
   logic              ready;
   logic              accepted;
   logic [SLOT_W-1:0] assigned_slot;
   logic              kick;

   modport source (output valid, output accepted, output assigned_slot, output kick,
                   input ready);
   modport sink   (input valid, input accepted, input assigned_slot, input kick,
                   output ready);
endinterface

/* hdl/mtwd_store.sv */
// Slot store: deadline and elapsed memories, one write and one registered read port.
module mtwd_store #(
   parameter int NUM_SLOTS = mtwd_pkg::NUM_SLOTS_DEF,
   parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                 clock,
   input  mtwd_pkg::mem_cmd_type cmd,
   input  logic [IDX_W-1:0]     rd_addr,
   input  logic [IDX_W-1:0]     wr_addr,
   output mtwd_pkg::mem_rd_type  rd_data
);
   import mtwd_pkg::*;

   logic [TIME_W-1:0] dl_mem [NUM_SLOTS];
   logic [TIME_W-1:0] el_mem [NUM_SLOTS];
   mem_rd_type        rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_dl_en) begin
         dl_mem[wr_addr] <= cmd.wr_dl;
      end
      if (cmd.wr_el_en) begin
         el_mem[wr_addr] <= cmd.wr_el;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff.deadline <= dl_mem[rd_addr];
         rdata_ff.elapsed  <= el_mem[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

/* hdl/mtwd_ctrl.sv */
// Sequencer: slot flags, command decode, tick walk over the store, response register.
module mtwd_ctrl #(
   parameter int NUM_SLOTS = mtwd_pkg::NUM_SLOTS_DEF,
   parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   mtwd_req_if.sink                    req_chan,
   mtwd_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [mtwd_pkg::TIME_W-1:0] csr_wr_data,
   output mtwd_pkg::mem_cmd_type        mem_cmd,
   output logic [IDX_W-1:0]            mem_rd_addr,
   output logic [IDX_W-1:0]            mem_wr_addr,
   input  mtwd_pkg::mem_rd_type         mem_rd_data
);
   import mtwd_pkg::*;

   localparam int EXT_W = IDX_W + SLOT_W;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  kick_ff, kick_in;
   logic [NUM_SLOTS-1:0]  used_ff, used_in;
   logic [NUM_SLOTS-1:0]  active_ff, active_in;
   logic [TIME_W-1:0]     tick_inc_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  acc_ff, acc_in;
   logic [SLOT_W-1:0]     asg_ff, asg_in;
   logic                  rkick_ff, rkick_in;

   logic                  req_fire;
   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic [EXT_W-1:0]      free_ext;
   logic [EXT_W-1:0]      slot_ext;
   logic [IDX_W-1:0]      slot_idx;
   logic                  slot_ok;
   logic                  live;
   logic                  below;
   logic                  expired;
   logic [TIME_W:0]       sum;
   logic [TIME_W-1:0]     sat;

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.accepted      = acc_ff;
   assign rsp_chan.assigned_slot = asg_ff;
   assign rsp_chan.kick          = rkick_ff;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign free_ext = {{SLOT_W{1'b0}}, free_idx};
   assign slot_ext = {{IDX_W{1'b0}}, req_chan.slot};
   assign slot_idx = slot_ext[IDX_W-1:0];
   assign slot_ok  = (slot_ext < EXT_W'(NUM_SLOTS)) && used_ff[slot_idx];

   // tick evaluation of the slot whose read data has just returned
   assign live    = pend_ff && used_ff[pend_idx_ff] && active_ff[pend_idx_ff];
   assign below   = mem_rd_data.elapsed < mem_rd_data.deadline;
   assign expired = live && !below;
   assign sum     = {1'b0, mem_rd_data.elapsed} + {1'b0, tick_inc_ff};
   assign sat     = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      kick_in      = kick_ff;
      used_in      = used_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      acc_in       = acc_ff;
      asg_in       = asg_ff;
      rkick_in     = rkick_ff;
      mem_cmd      = '0;
      mem_rd_addr  = cnt_ff;
      mem_wr_addr  = pend_idx_ff;

      if (live && below) begin
         mem_cmd.wr_el_en = 1'b1;
         mem_cmd.wr_el    = sat;
      end
      if (expired) begin
         kick_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               acc_in       = 1'b0;
               asg_in       = '0;
               rkick_in     = 1'b0;
               case (req_chan.kind)
                  KIND_ADD: begin
                     if (free_found) begin
                        used_in[free_idx]   = 1'b1;
                        active_in[free_idx] = 1'b0;
                        mem_wr_addr         = free_idx;
                        mem_cmd.wr_dl_en    = 1'b1;
                        mem_cmd.wr_dl       = req_chan.timeout_value;
                        mem_cmd.wr_el_en    = 1'b1;
                        mem_cmd.wr_el       = '0;
                        acc_in              = 1'b1;
                        asg_in              = free_ext[SLOT_W-1:0];
                     end
                  end
                  KIND_REMOVE: begin
                     if (slot_ok) begin
                        used_in[slot_idx]   = 1'b0;
                        active_in[slot_idx] = 1'b0;
                        acc_in              = 1'b1;
                     end
                  end
                  KIND_START, KIND_IDLE: begin
                     if (slot_ok) begin
                        active_in[slot_idx] = (req_chan.kind == KIND_START);
                        mem_wr_addr         = slot_idx;
                        mem_cmd.wr_el_en    = 1'b1;
                        mem_cmd.wr_el       = '0;
                        acc_in              = 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_WALK;
                     cnt_in       = '0;
                     kick_in      = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            mem_cmd.rd_en = 1'b1;
            pend_in       = 1'b1;
            pend_idx_in   = cnt_ff;
            if (cnt_ff == IDX_W'(NUM_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // last slot evaluated here; the output is empty since tick acceptance
            rsp_valid_in = 1'b1;
            acc_in       = 1'b1;
            asg_in       = '0;
            rkick_in     = kick_ff && !expired;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         active_ff    <= '0;
         tick_inc_ff  <= TICK_INC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         used_ff      <= used_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tick_inc_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      pend_idx_ff <= pend_idx_in;
      kick_ff     <= kick_in;
      acc_ff      <= acc_in;
      asg_ff      <= asg_in;
      rkick_ff    <= rkick_in;
   end

endmodule

/* hdl/multi_task_watchdog_table.sv */
// Top level of the multi-task watchdog table: sequencer plus slot store.
//
//   channel   direction  handshake        contents
//   req_chan  in         valid/ready      kind, slot, timeout_value
//   rsp_chan  out        valid/ready      accepted, assigned_slot, kick
//   csr_*     in         write enable     tick_increment (16 bit)
//
// Add, remove, start, idle: response valid the cycle after the transaction.
// Tick: walks all NUM_SLOTS slots through the store's single read port, one per
//   cycle, then settles the last slot in the drain state and registers the response.
// Reset clears the used/active flags and sets tick_increment to 1; memories are
//   not cleared, an add writes a slot before its contents are ever used.
// A new transaction is taken in the idle state once the response register is empty or being read.
module multi_task_watchdog_table #(
   parameter int NUM_SLOTS = mtwd_pkg::NUM_SLOTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   mtwd_req_if.sink                    req_chan,
   mtwd_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [mtwd_pkg::TIME_W-1:0] csr_wr_data
);
   import mtwd_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   mem_cmd_type      mem_cmd;
   mem_rd_type       mem_rd_data;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [IDX_W-1:0] mem_wr_addr;

   mtwd_ctrl #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_cmd     (mem_cmd),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_data (mem_rd_data)
   );

   mtwd_store #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* dv/multi_task_watchdog_table_tb.sv */
// Self-checking testbench for the task watchdog table: directed and random traffic.
`timescale 1ns / 100ps

module multi_task_watchdog_table_tb;
   import mtwd_pkg::*;

   localparam int SLOTS      = NUM_SLOTS_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES     = 7;
   localparam int PHASE_ITEMS = 110;
   localparam logic [KIND_W-1:0] KIND_LAST  = '1;
   localparam logic [KIND_W-1:0] KIND_SPARE = KIND_TICK + KIND_W'(1);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] timeout_value;
   } req_item_type;

   typedef struct packed {
      logic              accepted;
      logic [SLOT_W-1:0] assigned_slot;
      logic              kick;
   } rsp_item_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [TIME_W-1:0] csr_wr_data;

   mtwd_req_if req_if ();
   mtwd_rsp_if rsp_if ();

   multi_task_watchdog_table #(.NUM_SLOTS(SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predicted table contents
   bit                claimed [SLOTS];
   bit                running [SLOTS];
   logic [TIME_W-1:0] deadline_ms [SLOTS];
   logic [TIME_W-1:0] age_ms [SLOTS];
   logic [TIME_W-1:0] tick_step;

   req_item_type req_backlog[$];
   rsp_item_type rsp_due[$];
   req_item_type req_now;
   int           req_wait;
   int           rsp_wait;
   int           idle_cycles;
   int           errors;
   bit           steady;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_item_type apply_request(input req_item_type it);
      rsp_item_type    r;
      logic [TIME_W:0] sum;
      bit              done;
      int              s;
      r    = '0;
      done = 1'b0;
      s    = int'(it.slot);
      case (it.kind)
         KIND_ADD: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && !claimed[i]) begin
                  claimed[i]     = 1'b1;
                  running[i]     = 1'b0;
                  deadline_ms[i] = it.timeout_value;
                  age_ms[i]      = '0;
                  r.accepted      = 1'b1;
                  r.assigned_slot = SLOT_W'(i);
                  done            = 1'b1;
               end
            end
         end
         KIND_REMOVE: begin
            if (s < SLOTS && claimed[s]) begin
               claimed[s] = 1'b0;
               running[s] = 1'b0;
               r.accepted = 1'b1;
            end
         end
         KIND_START, KIND_IDLE: begin
            if (s < SLOTS && claimed[s]) begin
               running[s] = (it.kind == KIND_START);
               age_ms[s]  = '0;
               r.accepted = 1'b1;
            end
         end
         KIND_TICK: begin
            r.accepted = 1'b1;
            r.kick     = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
               if (claimed[i] && running[i]) begin
                  if (age_ms[i] < deadline_ms[i]) begin
                     sum       = {1'b0, age_ms[i]} + {1'b0, tick_step};
                     age_ms[i] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                  end else begin
                     r.kick = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Mostly well-formed traffic aimed at slots in use; a little noise.
   function automatic req_item_type random_item();
      req_item_type it;
      int           taken[$];
      int           pick;
      int           add_w;
      int           rem_w;
      logic [31:0]  prod;
      for (int i = 0; i < SLOTS; i++)
         if (claimed[i]) taken.push_back(i);
      add_w = (taken.size() < SLOTS) ? 20 : 5;
      rem_w = (taken.size() > SLOTS - 3) ? 20 : 8;
      it.timeout_value = TIME_W'($urandom);
      it.slot          = SLOT_W'($urandom);
      if (taken.size() != 0 && $urandom_range(0, 99) < 85)
         it.slot = SLOT_W'(taken[$urandom_range(0, taken.size() - 1)]);
      pick = $urandom_range(0, 99 + add_w + rem_w);
      if (pick < add_w) begin
         it.kind = KIND_ADD;
         case ($urandom_range(0, 3))
            0: it.timeout_value = TIME_W'($urandom_range(0, 20));
            1: it.timeout_value = TIME_W'($urandom);
            2: it.timeout_value = $urandom_range(0, 1) ? '1 : '0;
            default: begin
               prod = tick_step * $urandom_range(0, 8);
               it.timeout_value = (prod > 32'hFFFF) ? '1 : prod[TIME_W-1:0];
            end
         endcase
      end else if (pick < add_w + rem_w) begin
         it.kind = KIND_REMOVE;
      end else if (pick < add_w + rem_w + 20) begin
         it.kind = KIND_START;
      end else if (pick < add_w + rem_w + 32) begin
         it.kind = KIND_IDLE;
      end else if (pick < add_w + rem_w + 95) begin
         it.kind = KIND_TICK;
      end else begin
         it.kind = KIND_W'($urandom_range(int'(KIND_ADD), int'(KIND_LAST)));
      end
      return it;
   endfunction

   task automatic push_req(input logic [KIND_W-1:0] k, input int s,
                           input logic [TIME_W-1:0] t);
      req_item_type it;
      it.kind          = k;
      it.slot          = SLOT_W'(s);
      it.timeout_value = t;
      req_backlog.push_back(it);
   endtask

   task automatic write_tick_step(input logic [TIME_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= TIME_W'($urandom);
      tick_step = value;
   endtask

   // drain everything, then allow for a tick walk still in flight
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_if.valid || rsp_due.size() != 0)
         @(posedge clock);
      repeat (SLOTS + 4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      req_item_type it;
      logic         busy;
      busy = req_if.valid;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            rsp_due.push_back(apply_request(req_now));
            busy = 1'b0;
         end
         if (!busy) begin
            if (req_wait > 0) begin
               req_wait--;
               req_if.valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               it      = req_backlog.pop_front();
               req_now = it;
               req_if.kind          <= it.kind;
               req_if.slot          <= it.slot;
               req_if.timeout_value <= it.timeout_value;
               req_if.valid         <= 1'b1;
               req_wait = steady ? 0 : $urandom_range(0, 3);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (rsp_due.size() == 0) begin
               $error("response with no transaction outstanding");
               errors++;
            end else begin
               want = rsp_due.pop_front();
               if (rsp_if.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp_if.accepted);
                  errors++;
               end
               if (rsp_if.assigned_slot !== want.assigned_slot) begin
                  $error("assigned_slot: expected %0d, got %0d",
                         want.assigned_slot, rsp_if.assigned_slot);
                  errors++;
               end
               if (rsp_if.kick !== want.kick) begin
                  $error("kick: expected %0d, got %0d", want.kick, rsp_if.kick);
                  errors++;
               end
            end
            rsp_wait = steady ? 0 : $urandom_range(0, 3);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // hang detector
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [TIME_W-1:0] step;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_if.valid         = 1'b0;
      req_if.kind          = KIND_ADD;
      req_if.slot          = '0;
      req_if.timeout_value = '0;
      rsp_if.ready         = 1'b0;
      req_wait    = 0;
      rsp_wait    = 0;
      idle_cycles = 0;
      errors      = 0;
      steady      = 1'b0;
      tick_step   = TICK_INC_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         claimed[i]     = 1'b0;
         running[i]     = 1'b0;
         deadline_ms[i] = '0;
         age_ms[i]      = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, free slots, zero deadline, expiry, full table
      push_req(KIND_TICK,   0, 16'h1234);
      push_req(KIND_START,  0, '0);
      push_req(KIND_REMOVE, 7, '1);
      push_req(KIND_IDLE,   3, '0);
      push_req(KIND_ADD,    5, '0);
      push_req(KIND_ADD,    0, '1);
      push_req(KIND_ADD,    0, 16'd2);
      push_req(KIND_START,  0, '0);
      push_req(KIND_START,  2, '0);
      push_req(KIND_TICK,   0, '0);
      push_req(KIND_TICK,   0, '0);
      push_req(KIND_IDLE,   0, '0);
      push_req(KIND_TICK,   0, '0);   // slot 2 now at its deadline
      push_req(KIND_START,  2, '0);
      push_req(KIND_TICK,   0, '0);
      for (int i = 0; i < 5; i++)
         push_req(KIND_ADD, 0, 16'd5);
      push_req(KIND_ADD,    0, 16'd9);   // table full
      push_req(KIND_REMOVE, 1, '0);
      push_req(KIND_ADD,    7, 16'd100);
      push_req(KIND_SPARE,  7, '1);
      push_req(KIND_LAST,   5, 16'h5A5A);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: step = '1;
            1: step = '0;
            2: step = TIME_W'(3);
            3: step = TIME_W'($urandom_range(30000, 65535));
            4: step = TIME_W'($urandom_range(1, 65535));
            5: step = TIME_W'(1);
            default: step = TIME_W'($urandom_range(1, 20));
         endcase
         write_tick_step(step);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            while (req_backlog.size() >= 2) @(posedge clock);
            req_backlog.push_back(random_item());
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/mtwd_pkg.sv
hdl/mtwd_if.sv
hdl/mtwd_store.sv
hdl/mtwd_ctrl.sv
hdl/multi_task_watchdog_table.sv
dv/multi_task_watchdog_table_tb.sv
